>>> hdl/kas_pkg.sv
// ----------------------------------------------------------------------------
// kas_pkg
// Types, sizes and codes shared by the keyed alert suppressor.
// ----------------------------------------------------------------------------
package kas_pkg;

  localparam int unsigned ENTRIES = 256;
  localparam int unsigned CNT_W   = $clog2(ENTRIES + 1);

  localparam int unsigned KEY_W   = 48;
  localparam int unsigned SCORE_W = 7;
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned COOL_W  = 16;
  localparam int unsigned CFG_W   = 16;
  localparam int unsigned CIDX_W  = 2;

  localparam logic [CIDX_W-1:0] CFG_THRESHOLD = 2'd0;
  localparam logic [CIDX_W-1:0] CFG_MARGIN    = 2'd1;
  localparam logic [CIDX_W-1:0] CFG_COOLDOWN  = 2'd2;

  localparam logic [SCORE_W-1:0] THRESHOLD_RST = 7'd40;
  localparam logic [SCORE_W-1:0] MARGIN_RST    = 7'd15;
  localparam logic [COOL_W-1:0]  COOLDOWN_RST  = 16'd300;

  localparam logic [2:0] OUT_BELOW    = 3'd0;
  localparam logic [2:0] OUT_NEW      = 3'd1;
  localparam logic [2:0] OUT_RISE     = 3'd2;
  localparam logic [2:0] OUT_COOLDOWN = 3'd3;
  localparam logic [2:0] OUT_SUPPRESS = 3'd4;
  localparam logic [2:0] OUT_FULL     = 3'd5;

  typedef struct packed {
    logic [KEY_W-1:0]   device_key;
    logic [SCORE_W-1:0] score;
    logic [TIME_W-1:0]  now_seconds;
  } kas_in_t;

  typedef struct packed {
    logic       alert;
    logic [2:0] outcome;
  } kas_out_t;

  typedef struct packed {
    logic [KEY_W-1:0]   key;
    logic [SCORE_W-1:0] score;
    logic [TIME_W-1:0]  stamp;
  } kas_entry_t;

  typedef struct packed {
    logic [SCORE_W-1:0] rise_margin;
    logic [COOL_W-1:0]  cooldown;
  } kas_cfg_t;

  typedef struct packed {
    logic active;
    logic shift;
    logic refresh;
  } kas_ctrl_t;

  typedef struct packed {
    logic hit;
    logic rise;
    logic cooled;
  } kas_stat_t;

endpackage

>>> hdl/kas_cell.sv
// ----------------------------------------------------------------------------
// kas_cell
// One table entry: key match, rise and cooldown checks, refresh and shift.
// ----------------------------------------------------------------------------
module kas_cell
  import kas_pkg::*;
(
  input  logic       clk_i,
  input  kas_in_t    query_i,
  input  kas_cfg_t   cfg_i,
  input  kas_ctrl_t  ctrl_i,
  input  kas_entry_t prev_i,
  output kas_entry_t entry_o,
  output kas_stat_t  stat_o
);

  kas_entry_t entry_q;
  kas_entry_t entry_d;
  logic [TIME_W-1:0]  age;
  logic [SCORE_W:0]   need;

  assign age  = query_i.now_seconds - entry_q.stamp;
  assign need = {1'b0, entry_q.score} + {1'b0, cfg_i.rise_margin};

  assign stat_o.hit    = ctrl_i.active && (entry_q.key == query_i.device_key);
  assign stat_o.rise   = {1'b0, query_i.score} >= need;
  assign stat_o.cooled = age >= {{(TIME_W-COOL_W){1'b0}}, cfg_i.cooldown};

  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.shift) begin
      entry_d = prev_i;
    end else if (ctrl_i.refresh && stat_o.hit) begin
      entry_d.score = query_i.score;
      entry_d.stamp = query_i.now_seconds;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

>>> hdl/keyed_alert_suppressor_unit.sv
// ----------------------------------------------------------------------------
// keyed_alert_suppressor_unit
// Alert deduplication with cooldown over a shifting chain of key cells.
// ----------------------------------------------------------------------------
// channel  | signals                               | direction
// input    | in_valid_i, in_ready_o, in_data_i     | transaction in
// output   | out_valid_o, out_ready_i, out_data_o  | transaction out
// config   | cfg_we_i, cfg_index_i, cfg_wdata_i    | register write
//
// A transaction is captured in the idle state, the only one taking input;
// the evaluation state does the parallel match in all cells and the refresh
// or insert. New keys shift in at cell 0. Reset clears the fill count and
// handshake state and loads the config defaults, not query, result or cells.
// A stalled output holds evaluation until the result register is free.
// ----------------------------------------------------------------------------
module keyed_alert_suppressor_unit
  import kas_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  kas_in_t           in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output kas_out_t          out_data_o,
  input  logic              cfg_we_i,
  input  logic [CIDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]  cfg_wdata_i
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EVAL = 1'b1;

  logic               state_q, state_d;
  kas_in_t            query_q;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [SCORE_W-1:0] thr_q;
  kas_cfg_t           cfg_q;
  logic               out_valid_q, out_valid_d;
  kas_out_t           out_data_q, out_data_d;

  kas_entry_t         entries [ENTRIES];
  kas_stat_t          stats   [ENTRIES];
  logic [ENTRIES-1:0] hit_v, rise_v, cool_v;

  logic fire, above, any_hit, rise_hit, cool_hit, full, do_shift, do_refresh;

  assign in_ready_o = (state_q == ST_IDLE);
  assign fire       = (state_q == ST_EVAL) && (!out_valid_q || out_ready_i);
  assign above      = query_q.score >= thr_q;
  assign full       = (cnt_q == CNT_W'(ENTRIES));

  assign any_hit    = |hit_v;
  assign rise_hit   = |(hit_v & rise_v);
  assign cool_hit   = |(hit_v & cool_v);
  assign do_refresh = fire && above && (rise_hit || cool_hit);
  assign do_shift   = fire && above && !any_hit && !full;

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    kas_ctrl_t  ctrl;
    kas_entry_t prev;

    assign ctrl.active  = CNT_W'(i) < cnt_q;
    assign ctrl.shift   = do_shift;
    assign ctrl.refresh = do_refresh;

    if (i == 0) begin : g_head
      assign prev.key   = query_q.device_key;
      assign prev.score = query_q.score;
      assign prev.stamp = query_q.now_seconds;
    end else begin : g_link
      assign prev = entries[i-1];
    end

    kas_cell u_cell (
      .clk_i   (clk_i),
      .query_i (query_q),
      .cfg_i   (cfg_q),
      .ctrl_i  (ctrl),
      .prev_i  (prev),
      .entry_o (entries[i]),
      .stat_o  (stats[i])
    );

    assign hit_v[i]  = stats[i].hit;
    assign rise_v[i] = stats[i].rise;
    assign cool_v[i] = stats[i].cooled;
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_data_d  = out_data_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (fire) begin
          state_d     = ST_IDLE;
          out_valid_d = 1'b1;
          if (!above) begin
            out_data_d = '{alert: 1'b0, outcome: OUT_BELOW};
          end else if (any_hit) begin
            if (rise_hit) begin
              out_data_d = '{alert: 1'b1, outcome: OUT_RISE};
            end else if (cool_hit) begin
              out_data_d = '{alert: 1'b1, outcome: OUT_COOLDOWN};
            end else begin
              out_data_d = '{alert: 1'b0, outcome: OUT_SUPPRESS};
            end
          end else if (full) begin
            out_data_d = '{alert: 1'b1, outcome: OUT_FULL};
          end else begin
            out_data_d = '{alert: 1'b1, outcome: OUT_NEW};
            cnt_d      = cnt_q + CNT_W'(1);
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      thr_q       <= THRESHOLD_RST;
      cfg_q       <= '{rise_margin: MARGIN_RST, cooldown: COOLDOWN_RST};
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_THRESHOLD: thr_q             <= cfg_wdata_i[SCORE_W-1:0];
          CFG_MARGIN:    cfg_q.rise_margin <= cfg_wdata_i[SCORE_W-1:0];
          CFG_COOLDOWN:  cfg_q.cooldown    <= cfg_wdata_i[COOL_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
    if (in_valid_i && in_ready_o) begin
      query_q <= in_data_i;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule
